// ===== hdl/wod_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the wheel
// odometry block. No dependencies.
`default_nettype none

package wod_pkg;

  // Build-time constants
  localparam int CORDIC_STEPS = 16;
  localparam int ACCUM_BITS   = 48;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int STEP_W       = $clog2(CORDIC_ITERS);

  localparam int TRIG_W = 33;  // CORDIC x, y, z (Q2.30 and turn angle)
  localparam int GAIN_W = 17;

  localparam logic [GAIN_W-1:0]        GAIN_RESET  = 17'd70217;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;

  typedef struct packed {
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic [15:0]        heading;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic signed [31:0] turn_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] pose_x;
    logic signed [47:0] pose_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] angular_rate;
  } out_item_t;

  // Operations of the shared multiplier
  typedef enum logic [2:0] {
    OP_GAIN,  // mean speed times gain
    OP_RC,    // travel times cosine
    OP_RS,    // travel times sine
    OP_SC,    // scaled speed times cosine
    OP_SS     // scaled speed times sine
  } mul_op_e;

  typedef struct packed {
    logic              load;   // capture an accepted item
    logic              prep;   // form the travel from the wheel deltas
    logic              iter;   // one CORDIC rotation
    logic [STEP_W-1:0] step;
    logic              flip;   // undo the half-turn fold
    logic              mul_en;
    mul_op_e           mul_op;
    logic              emit;   // load the output register
  } dp_cmd_t;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/wod_dp.sv =====
// Datapath of the wheel odometry block: CORDIC shift-add unit, shared
// multiplier with rounding stage, pose accumulators and output register. Uses wod_pkg.
`default_nettype none

module wod_dp
  import wod_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  input  wire in_item_t          in_data_i,
  input  wire logic              cfg_we_i,
  input  wire logic [GAIN_W-1:0] cfg_wdata_i,
  output out_item_t              out_data_o
);

  localparam int MA_W   = 34;
  localparam int MB_W   = TRIG_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int RND_W  = 37;
  localparam int SUM_W  = ((ACCUM_BITS > RND_W) ? ACCUM_BITS : RND_W) + 1;
  localparam int POSE_W = ((ACCUM_BITS > 48) ? ACCUM_BITS : 48) + 1;

  localparam logic signed [PROD_W-1:0] HALF_Q16 = PROD_W'(1) << 15;
  localparam logic signed [PROD_W-1:0] HALF_Q30 = PROD_W'(1) << 29;

  function automatic logic signed [ACCUM_BITS-1:0] sat_acc(
    input logic signed [ACCUM_BITS-1:0] acc,
    input logic signed [RND_W-1:0]      d
  );
    logic signed [SUM_W-1:0]      s;
    logic [SUM_W-ACCUM_BITS:0]    top;
    logic signed [ACCUM_BITS-1:0] r;
    s   = SUM_W'(acc) + SUM_W'(d);
    top = s[SUM_W-1:ACCUM_BITS-1];
    if ((&top) || !(|top)) begin
      r = s[ACCUM_BITS-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(ACCUM_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACCUM_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] v);
    logic [RND_W-32:0]  top;
    logic signed [31:0] r;
    top = v[RND_W-1:31];
    if ((&top) || !(|top)) begin
      r = v[31:0];
    end else if (v[RND_W-1]) begin
      r = {1'b1, {31{1'b0}}};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat_pose(
    input logic signed [ACCUM_BITS-1:0] acc
  );
    logic signed [POSE_W-1:0] e;
    logic [POSE_W-48:0]       top;
    logic signed [47:0]       r;
    e   = POSE_W'(acc);
    top = e[POSE_W-1:47];
    if ((&top) || !(|top)) begin
      r = e[47:0];
    end else if (e[POSE_W-1]) begin
      r = {1'b1, {47{1'b0}}};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  // Configuration and persistent state
  logic [GAIN_W-1:0]            gain_q;
  logic signed [32:0]           last_sum_q;
  logic signed [ACCUM_BITS-1:0] accum_x_q, accum_x_d;
  logic signed [ACCUM_BITS-1:0] accum_y_q, accum_y_d;

  // Per-item working registers
  logic signed [32:0]       pos_sum_q;
  logic signed [32:0]       r_q;
  logic signed [31:0]       v_q;
  logic signed [31:0]       turn_q;
  logic                     flip_q;
  logic signed [TRIG_W-1:0] x_q, y_q, z_q;
  logic signed [MA_W-1:0]   scaled_q;
  logic signed [31:0]       vx_q, vy_q;

  // Multiplier pipeline
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rsum;
  logic signed [RND_W-1:0]  rnd_q, rnd_d;
  logic                     m1_vld_q, m2_vld_q;
  mul_op_e                  m1_op_q, m2_op_q;

  // Item capture
  logic signed [32:0]       spd_sum;
  logic signed [32:0]       z_raw, z_fold;
  logic                     fold;
  logic signed [33:0]       delta;

  // CORDIC step
  logic signed [TRIG_W-1:0] dx, dy, atn;

  out_item_t out_q;

  always_comb begin
    spd_sum = 33'(in_data_i.left_speed) + 33'(in_data_i.right_speed);
    z_raw   = 33'($signed({in_data_i.heading, 16'h0000}));
    fold    = 1'b0;
    z_fold  = z_raw;
    if (z_raw > 33'sd1073741824) begin
      z_fold = z_raw - 33'sd2147483648;
      fold   = 1'b1;
    end else if (z_raw < -33'sd1073741824) begin
      z_fold = z_raw + 33'sd2147483648;
      fold   = 1'b1;
    end
    delta = 34'(pos_sum_q) - 34'(last_sum_q);
  end

  always_comb begin
    dx  = y_q >>> cmd_i.step;
    dy  = x_q >>> cmd_i.step;
    atn = $signed(TRIG_W'(atan_turn(5'(cmd_i.step))));
  end

  // Operand selection for the shared multiplier
  always_comb begin
    case (cmd_i.mul_op)
      OP_GAIN: begin
        ma = MA_W'(v_q);
        mb = MB_W'($signed({1'b0, gain_q}));
      end
      OP_RC: begin
        ma = MA_W'(r_q);
        mb = x_q;
      end
      OP_RS: begin
        ma = MA_W'(r_q);
        mb = y_q;
      end
      OP_SC: begin
        ma = scaled_q;
        mb = x_q;
      end
      OP_SS: begin
        ma = scaled_q;
        mb = y_q;
      end
      default: begin
        ma = scaled_q;
        mb = y_q;
      end
    endcase
  end

  // Round half up, Q16 for the gain and Q30 for the trig products
  always_comb begin
    rsum  = prod_q + ((m1_op_q == OP_GAIN) ? HALF_Q16 : HALF_Q30);
    rnd_d = (m1_op_q == OP_GAIN) ? RND_W'(rsum >>> 16) : RND_W'(rsum >>> 30);
  end

  always_comb begin
    accum_x_d = accum_x_q;
    accum_y_d = accum_y_q;
    if (m2_vld_q && (m2_op_q == OP_RC)) begin
      accum_x_d = sat_acc(accum_x_q, rnd_q);
    end
    if (m2_vld_q && (m2_op_q == OP_RS)) begin
      accum_y_d = sat_acc(accum_y_q, rnd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GAIN_RESET;
      last_sum_q <= '0;
      accum_x_q  <= '0;
      accum_y_q  <= '0;
      m1_vld_q   <= 1'b0;
      m2_vld_q   <= 1'b0;
      m1_op_q    <= OP_GAIN;
      m2_op_q    <= OP_GAIN;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (cmd_i.prep) begin
        last_sum_q <= pos_sum_q;
      end
      accum_x_q <= accum_x_d;
      accum_y_q <= accum_y_d;
      m1_vld_q  <= cmd_i.mul_en;
      m1_op_q   <= cmd_i.mul_op;
      m2_vld_q  <= m1_vld_q;
      m2_op_q   <= m1_op_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_sum_q <= 33'(in_data_i.left_position) + 33'(in_data_i.right_position);
      v_q       <= spd_sum[32:1];
      turn_q    <= in_data_i.turn_rate;
      z_q       <= z_fold;
      flip_q    <= fold;
      x_q       <= CORDIC_GAIN;
      y_q       <= '0;
    end
    if (cmd_i.prep) begin
      r_q <= delta[33:1];
    end
    if (cmd_i.iter) begin
      if (!z_q[TRIG_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atn;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atn;
      end
    end
    if (cmd_i.flip && flip_q) begin
      x_q <= -x_q;
      y_q <= -y_q;
    end
    prod_q <= ma * mb;
    rnd_q  <= rnd_d;
    if (m2_vld_q && (m2_op_q == OP_GAIN)) begin
      scaled_q <= rnd_q[MA_W-1:0];
    end
    if (m2_vld_q && (m2_op_q == OP_SC)) begin
      vx_q <= sat32(rnd_q);
    end
    if (m2_vld_q && (m2_op_q == OP_SS)) begin
      vy_q <= sat32(rnd_q);
    end
    if (cmd_i.emit) begin
      out_q.pose_x       <= sat_pose(accum_x_q);
      out_q.pose_y       <= sat_pose(accum_y_q);
      out_q.velocity_x   <= vx_q;
      out_q.velocity_y   <= vy_q;
      out_q.angular_rate <= turn_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== hdl/wod_ctrl.sv =====
// Sequencer of the wheel odometry block: input handshake, CORDIC and multiply
// scheduling, output valid. Uses wod_pkg; drives wod_dp through dp_cmd_t.
`default_nettype none

module wod_ctrl
  import wod_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output dp_cmd_t   cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_ROT   = 3'd2;
  localparam logic [2:0] ST_FLIP  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [STEP_W-1:0] LAST_ITER = STEP_W'(CORDIC_ITERS - 1);
  localparam logic [STEP_W-1:0] LAST_MUL  = STEP_W'(4);
  localparam logic [STEP_W-1:0] LAST_WAIT = STEP_W'(1);

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.step   = cnt_q;
    cmd_o.mul_op = OP_GAIN;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.iter = 1'b1;
        if (cnt_q == LAST_ITER) begin
          cnt_d   = '0;
          state_d = ST_FLIP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FLIP: begin
        cmd_o.flip = 1'b1;
        cnt_d      = '0;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        case (cnt_q[2:0])
          3'd0:    cmd_o.mul_op = OP_GAIN;
          3'd1:    cmd_o.mul_op = OP_RC;
          3'd2:    cmd_o.mul_op = OP_RS;
          3'd3:    cmd_o.mul_op = OP_SC;
          default: cmd_o.mul_op = OP_SS;
        endcase
        if (cnt_q == LAST_MUL) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait for the last products to clear round and writeback
        if (cnt_q == LAST_WAIT) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_PREP))
    else $error("accepted item did not start processing");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an untaken result");

  a_rose_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result appeared outside the completion state");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT) |-> (cnt_q <= LAST_ITER))
    else $error("CORDIC step count out of range");

endmodule

`default_nettype wire

// ===== hdl/wheel_odometry_dead_reckoning.sv =====
// Top level of the wheel odometry block: joins the sequencer wod_ctrl and the
// datapath wod_dp. Uses wod_pkg.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o / in_data_i (in_item_t). An item
//   is taken on a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i / out_data_o (out_item_t), one
//   result per item, held stable while out_stall_i is high.
//   Configuration: cfg_we_i writes cfg_wdata_i into the speed gain (Q1.16);
//   write only while no item is in flight.
// Processing:
//   One item at a time. The next item is taken once the result of the last
//   has been loaded into the output register. Processing time is set by the
//   shift-add CORDIC unit doing one rotation per cycle, plus five issues of
//   the shared multiplier and its two-stage round and writeback.
// Reset:
//   Clears the pose accumulators and the previous wheel position sum to zero,
//   sets the gain to 1.071426 and clears the output valid.
// Stall:
//   A held result does not block the next item; the block only waits at the
//   end of the next item until the output register is taken.
`default_nettype none

module wheel_odometry_dead_reckoning
  import wod_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [GAIN_W-1:0] cfg_wdata_i
);

  // commands from the sequencer to the datapath
  dp_cmd_t cmd;

  wod_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  wod_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_wheel_odometry_dead_reckoning.sv =====
// Self-checking bench for wheel_odometry_dead_reckoning: directed table and
// random drive phases, checked against a local predictor and hand-typed fields.
// Depends on wod_pkg (types, widths, CORDIC constants) and the block's RTL.
`default_nettype none

module tb_wheel_odometry_dead_reckoning;
  timeunit 1ns;
  timeprecision 1ps;

  import wod_pkg::*;

  // Run shape
  localparam int LATENCY         = CORDIC_ITERS + 10;  // edges from accept to result
  localparam int CYCLE_LIMIT     = 200_000;
  localparam int HOLD_CYCLES     = 400;                // long receiver hold-off
  localparam int IDLE_PCT        = 36;
  localparam int RAND_PHASES     = 4;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  // Fixed-point limits
  localparam longint ACC_MAX   = (longint'(1) <<< (ACCUM_BITS - 1)) - 1;
  localparam longint ACC_MIN   = -ACC_MAX - 1;
  localparam longint POSE_MAX  = (longint'(1) <<< 47) - 1;
  localparam longint POSE_MIN  = -POSE_MAX - 1;
  localparam longint VEL_MAX   = 64'sd2147483647;
  localparam longint VEL_MIN   = -64'sd2147483648;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint QTR_TURN  = 64'sd1073741824;

  // Handy input values
  localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] P_MIN = 32'h8000_0000;
  localparam logic [31:0] ONE_M = 32'h0001_0000;

  // Which result fields a directed row types in by hand
  localparam logic [4:0] K_PX  = 5'b00001;
  localparam logic [4:0] K_PY  = 5'b00010;
  localparam logic [4:0] K_VX  = 5'b00100;
  localparam logic [4:0] K_VY  = 5'b01000;
  localparam logic [4:0] K_AR  = 5'b10000;
  localparam logic [4:0] K_VEL = K_VX | K_VY;
  localparam logic [4:0] K_ALL = 5'b11111;

  typedef struct packed {
    in_item_t          item;
    logic [GAIN_W-1:0] gain;
    logic [4:0]        known;
    out_item_t         typed;
  } odom_row_t;

  // DUT ports
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic [GAIN_W-1:0] cfg_wdata_i = '0;

  // Predictor state: previous wheel positions, pose accumulators, gain
  longint            prev_left   = 0;
  longint            prev_right  = 0;
  longint            pose_acc_x  = 0;
  longint            pose_acc_y  = 0;
  logic [GAIN_W-1:0] gain_q16    = GAIN_RESET;

  out_item_t         predicted_odom_q[$];
  odom_row_t         odom_rows[$];
  out_item_t         odom_want;

  // Shared control between stimulus and receiver
  bit  idle_on     = 1'b1;
  bit  hold_req    = 1'b0;
  bit  hold_taken  = 1'b0;
  int  hold_left   = 0;
  int  mismatches  = 0;
  int  cycle_count = 0;

  wheel_odometry_dead_reckoning DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // atan(2^-i) in turns, 2^32 per turn
  function automatic longint turn_atan(input int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      23: return 81;
      default: return 0;
    endcase
  endfunction

  // Rotation-mode CORDIC: cos and sin of a binary-angle heading in Q2.30.
  // Fold headings past a quarter turn by half a turn and negate at the end.
  function automatic void cordic_trig(input logic [15:0] hdg, output longint c,
                                      output longint s);
    logic signed [31:0] ang;
    longint x, y, z, dx, dy;
    bit flip;
    int i;
    ang  = {hdg, 16'h0000};
    z    = ang;
    x    = CORDIC_GAIN;
    y    = 0;
    flip = 1'b0;
    if (z > QTR_TURN) begin
      z    = z - HALF_TURN;
      flip = 1'b1;
    end else if (z < -QTR_TURN) begin
      z    = z + HALF_TURN;
      flip = 1'b1;
    end
    for (i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - turn_atan(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + turn_atan(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Shift right by n with rounding half up
  function automatic longint round_shift(input longint p, input int n);
    return (p + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp64(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advance the dead-reckoning state by one item and return its result
  function automatic out_item_t dead_reckon(input in_item_t it);
    longint c, s, lp, rp, r, v, scaled;
    out_item_t res;
    cordic_trig(it.heading, c, s);
    lp = longint'($signed(it.left_position));
    rp = longint'($signed(it.right_position));
    // exact deltas, no wrap handling; floor of the mean
    r = ((lp - prev_left) + (rp - prev_right)) >>> 1;
    pose_acc_x = clamp64(pose_acc_x + round_shift(r * c, 30), ACC_MIN, ACC_MAX);
    pose_acc_y = clamp64(pose_acc_y + round_shift(r * s, 30), ACC_MIN, ACC_MAX);
    v = (longint'($signed(it.left_speed)) + longint'($signed(it.right_speed))) >>> 1;
    scaled = round_shift(v * longint'(gain_q16), 16);
    res.pose_x       = 48'(clamp64(pose_acc_x, POSE_MIN, POSE_MAX));
    res.pose_y       = 48'(clamp64(pose_acc_y, POSE_MIN, POSE_MAX));
    res.velocity_x   = 32'(clamp64(round_shift(scaled * c, 30), VEL_MIN, VEL_MAX));
    res.velocity_y   = 32'(clamp64(round_shift(scaled * s, 30), VEL_MIN, VEL_MAX));
    res.angular_rate = it.turn_rate;
    prev_left  = lp;
    prev_right = rp;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_row(input logic [31:0] lp, input logic [31:0] rp,
                         input logic [15:0] hdg, input logic [31:0] ls,
                         input logic [31:0] rs, input logic [31:0] tr,
                         input logic [GAIN_W-1:0] g, input logic [4:0] known,
                         input logic [31:0] tvx, input logic [31:0] tvy);
    odom_row_t row;
    row.item  = {lp, rp, hdg, ls, rs, tr};
    row.gain  = g;
    row.known = known;
    row.typed = {48'd0, 48'd0, tvx, tvy, tr};
    odom_rows.insert(odom_rows.size(), row);
  endtask

  // Offer one item; on acceptance predict it and queue the expected result.
  // Fields flagged in known take the hand-typed value instead.
  task automatic offer_item(input in_item_t it, input logic [4:0] known,
                            input out_item_t typed);
    out_item_t res;
    while (idle_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = dead_reckon(it);
    if (known & K_PX) res.pose_x       = typed.pose_x;
    if (known & K_PY) res.pose_y       = typed.pose_y;
    if (known & K_VX) res.velocity_x   = typed.velocity_x;
    if (known & K_VY) res.velocity_y   = typed.velocity_y;
    if (known & K_AR) res.angular_rate = typed.angular_rate;
    predicted_odom_q.insert(predicted_odom_q.size(), res);
  endtask

  // Drop valid, wait until every expected result is out, then pad
  task automatic settle(input int pad);
    in_valid_i <= 1'b0;
    while (predicted_odom_q.size() != 0) @(posedge clk_i);
    repeat (pad) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain_q16 = g;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: check each taken result, drive stall with random and long holds
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_odom_q.size() == 0) begin
        mismatches++;
        $error("result with no item waiting for it");
      end else begin
        odom_want = predicted_odom_q[0];
        predicted_odom_q.delete(0);
        check_field("pose_x",       odom_want.pose_x,       out_data_o.pose_x);
        check_field("pose_y",       odom_want.pose_y,       out_data_o.pose_y);
        check_field("velocity_x",   odom_want.velocity_x,   out_data_o.velocity_x);
        check_field("velocity_y",   odom_want.velocity_y,   out_data_o.velocity_y);
        check_field("angular_rate", odom_want.angular_rate, out_data_o.angular_rate);
      end
    end
    // hold off once for a long stretch so the block backs up into its input
    if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_wheel_odometry_dead_reckoning: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t          it;
    int                k, phase, n;
    logic signed [31:0] cur_lp, cur_rp, d;
    logic [15:0]       cur_hdg;
    logic [GAIN_W-1:0] g;

    // Directed table. Pose is typed in only for the first item after reset;
    // velocity where it is zero or clearly saturated; the turn rate always.
    // nothing moves straight after reset
    add_row(0, 0, 16'h0000, 0, 0, 0, GAIN_RESET, K_ALL, 0, 0);
    // one metre forward while standing still: zero velocity
    add_row(ONE_M, ONE_M, 16'h0000, 0, 0, P_MAX, GAIN_RESET, K_VEL | K_AR, 0, 0);
    // headings around the fold points of the CORDIC range
    add_row(2 * ONE_M, 2 * ONE_M, 16'h4000, ONE_M, ONE_M, 32'd1, GAIN_RESET, K_AR, 0, 0);
    add_row(3 * ONE_M, 3 * ONE_M, 16'h4001, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_FFFF,
            GAIN_RESET, K_AR, 0, 0);
    add_row(4 * ONE_M, 4 * ONE_M, 16'h8000, 32'h0002_8000, 32'h0001_8000, 32'h1234_5678,
            GAIN_RESET, K_AR, 0, 0);
    add_row(5 * ONE_M, 4 * ONE_M, 16'hBFFF, 32'h0003_0000, 32'h0001_0000, 32'hA5A5_A5A5,
            GAIN_RESET, K_AR, 0, 0);
    add_row(5 * ONE_M, 6 * ONE_M, 16'hC000, 32'h0000_8000, 32'h0001_0000, 32'h5A5A_5A5A,
            GAIN_RESET, K_AR, 0, 0);
    add_row(7 * ONE_M, 7 * ONE_M, 16'hFFFF, ONE_M, ONE_M, 32'h0000_0100, GAIN_RESET, K_AR,
            0, 0);
    add_row(6 * ONE_M, 6 * ONE_M, 16'h2000, ONE_M, 32'h0002_0000, 32'h0001_0000,
            GAIN_RESET, K_AR, 0, 0);
    // velocity overflow in every direction of the heading
    add_row(6 * ONE_M, 6 * ONE_M, 16'h0000, P_MAX, P_MAX, 32'd7, GAIN_RESET, K_VX | K_AR,
            P_MAX, 0);
    add_row(6 * ONE_M, 6 * ONE_M, 16'h0000, P_MIN, P_MIN, 32'd8, GAIN_RESET, K_VX | K_AR,
            P_MIN, 0);
    add_row(6 * ONE_M, 6 * ONE_M, 16'h4000, P_MAX, P_MAX, 32'd9, GAIN_RESET, K_VY | K_AR,
            0, P_MAX);
    add_row(6 * ONE_M, 6 * ONE_M, 16'h8000, P_MIN, P_MIN, 32'd10, GAIN_RESET, K_VX | K_AR,
            P_MAX, 0);
    add_row(6 * ONE_M, 6 * ONE_M, 16'hC000, P_MIN, P_MIN, 32'd11, GAIN_RESET, K_VY | K_AR,
            0, P_MAX);
    // opposite extreme speeds: mean rounds down to minus one
    add_row(6 * ONE_M, 6 * ONE_M, 16'h1000, P_MAX, P_MIN, 32'd12, GAIN_RESET, K_AR, 0, 0);
    // wheel position extremes and full-range swings of the deltas
    add_row(P_MAX, P_MAX, 16'h0000, 0, 0, P_MIN, GAIN_RESET, K_VEL | K_AR, 0, 0);
    add_row(P_MIN, P_MIN, 16'h0000, 0, 0, 32'd13, GAIN_RESET, K_VEL | K_AR, 0, 0);
    add_row(P_MAX, P_MIN, 16'h3000, 0, 0, 32'd14, GAIN_RESET, K_VEL | K_AR, 0, 0);
    add_row(P_MIN, P_MAX, 16'hE000, 0, 0, 32'd15, GAIN_RESET, K_VEL | K_AR, 0, 0);
    // zero gain kills any speed
    add_row(0, 0, 16'h2000, P_MAX, P_MAX, 32'd16, '0, K_VEL | K_AR, 0, 0);
    add_row(ONE_M, 0, 16'h6000, P_MIN, P_MIN, 32'd17, '0, K_VEL | K_AR, 0, 0);
    // full gain saturates both axes
    add_row(ONE_M, ONE_M, 16'h2000, P_MAX, P_MAX, 32'd18, GAIN_MAX, K_VEL | K_AR,
            P_MAX, P_MAX);
    add_row(ONE_M, ONE_M, 16'hA000, P_MIN, P_MIN, 32'd19, GAIN_MAX, K_VEL | K_AR,
            P_MAX, P_MAX);
    add_row(2 * ONE_M, ONE_M, 16'h0000, ONE_M, ONE_M, 32'd20, 17'd1, K_AR, 0, 0);
    add_row(2 * ONE_M, 2 * ONE_M, 16'h1234, ONE_M, 32'h0001_8000, 32'd21, GAIN_RESET,
            K_AR, 0, 0);

    // Hold reset, then release it on an edge
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table; change the gain only with the block drained
    for (k = 0; k < odom_rows.size(); k++) begin
      if (odom_rows[k].gain != gain_q16) begin
        settle(2);
        write_gain(odom_rows[k].gain);
      end
      offer_item(odom_rows[k].item, odom_rows[k].known, odom_rows[k].typed);
    end

    // Random motion starts from the last wheel positions of the table
    cur_lp  = 32'(prev_left);
    cur_rp  = 32'(prev_right);
    cur_hdg = 16'h0000;

    // Random drive in phases, each under its own gain; phase two runs with
    // no idling on either side
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      settle(2);
      if (phase == 1)      g = GAIN_RESET;
      else if (phase == 3) g = GAIN_MAX;
      else                 g = GAIN_W'($urandom_range(0, GAIN_MAX));
      write_gain(g);
      idle_on = (phase != 2);
      if (phase == 1) hold_req = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 75) begin
          // plausible motion: short wheel moves, slowly turning heading
          d       = $signed($urandom) >>> $urandom_range(8, 31);
          cur_lp  = cur_lp + d;
          cur_rp  = cur_rp + d + ($signed($urandom) >>> $urandom_range(16, 31));
          cur_hdg = 16'(cur_hdg + $urandom_range(0, 2047) - 1024);
          it.left_position  = cur_lp;
          it.right_position = cur_rp;
          it.heading        = cur_hdg;
          it.left_speed     = $signed($urandom) >>> $urandom_range(0, 31);
          it.right_speed    = $signed($urandom) >>> $urandom_range(0, 31);
          it.turn_rate      = $signed($urandom) >>> $urandom_range(0, 31);
        end else begin
          // noise: any value in every field
          it.left_position  = $urandom;
          it.right_position = $urandom;
          it.heading        = 16'($urandom);
          it.left_speed     = $urandom;
          it.right_speed    = $urandom;
          it.turn_rate      = $urandom;
          cur_lp  = it.left_position;
          cur_rp  = it.right_position;
          cur_hdg = it.heading;
        end
        offer_item(it, '0, '0);
      end
    end
    idle_on = 1'b1;

    // Drain and let any stray result show up
    settle(LATENCY);
    if (predicted_odom_q.size() != 0)
      $error("%0d expected results never arrived", predicted_odom_q.size());
    if (mismatches == 0 && predicted_odom_q.size() == 0)
      $display("tb_wheel_odometry_dead_reckoning: PASS");
    else
      $display("tb_wheel_odometry_dead_reckoning: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/wod_pkg.sv
hdl/wod_dp.sv
hdl/wod_ctrl.sv
hdl/wheel_odometry_dead_reckoning.sv
bench/tb_wheel_odometry_dead_reckoning.sv
